// ----- rtl/core/lavm_pkg.sv -----
// shared types and constants for the look-at view matrix block
package lavm_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned QDEPTH  = 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] aim_x;
    logic signed [COORD_W-1:0] aim_y;
    logic signed [COORD_W-1:0] aim_z;
  } in_t;

  typedef struct packed {
    logic [1:0]                row_index;
    logic signed [COORD_W-1:0] entry_0;
    logic signed [COORD_W-1:0] entry_1;
    logic signed [COORD_W-1:0] entry_2;
    logic signed [COORD_W-1:0] entry_3;
    logic                      last_row;
    logic                      degenerate;
  } out_t;

  // one classified request waiting for the back end
  typedef struct packed {
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [DIFF_W-1:0]  dif_x;
    logic signed [DIFF_W-1:0]  dif_y;
    logic signed [DIFF_W-1:0]  dif_z;
    logic                      fwd_zero;
    logic                      rgt_zero;
  } job_t;

endpackage

// ----- rtl/core/lavm_front.sv -----
// front end: forms the view direction and flags degenerate requests
module lavm_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  lavm_pkg::in_t in_data,
  input  logic          q_full,
  output logic          push,
  output lavm_pkg::job_t job
);
  import lavm_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    job.eye_x = in_data.eye_x;
    job.eye_y = in_data.eye_y;
    job.eye_z = in_data.eye_z;
    job.dif_x = DIFF_W'(in_data.aim_x) - DIFF_W'(in_data.eye_x);
    job.dif_y = DIFF_W'(in_data.aim_y) - DIFF_W'(in_data.eye_y);
    job.dif_z = DIFF_W'(in_data.aim_z) - DIFF_W'(in_data.eye_z);
    // same point: no forward; straight up or down: no right
    job.rgt_zero = (job.dif_x == '0) && (job.dif_z == '0);
    job.fwd_zero = job.rgt_zero && (job.dif_y == '0);
  end

endmodule

// ----- rtl/core/lavm_queue.sv -----
// short request queue between front and back end
module lavm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lavm_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output lavm_pkg::job_t head_data
);
  import lavm_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  job_t          slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full       = (count == (PW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- rtl/core/lavm_back.sv -----
// back end: normalize, cross and dot products, row output register
module lavm_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  lavm_pkg::job_t head_data,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output lavm_pkg::out_t out_data
);
  import lavm_pkg::*;

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned NW = FRAC_BITS + 32;
  localparam int unsigned DW = $clog2(QW);
  localparam int unsigned AW = 66;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PREP  = 10'b0000000010,
    S_SHIFT = 10'b0000000100,
    S_SQ    = 10'b0000001000,
    S_ROOT  = 10'b0000010000,
    S_DLOAD = 10'b0000100000,
    S_DSTEP = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_ACC   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state;
  job_t   job;
  logic   vsel;
  logic   degen;
  logic [1:0] idx;
  logic [1:0] row;
  logic [3:0] step;

  logic [32:0] mag [3];
  logic        neg [3];
  logic [63:0] sum;
  logic [63:0] root;
  logic [63:0] rbit;
  logic [31:0] len;
  logic [31:0] rem;
  logic [QW-1:0] lo;
  logic [QW-1:0] quo;
  logic [DW-1:0] dcnt;

  logic signed [31:0] f  [3];
  logic signed [31:0] r  [3];
  logic signed [31:0] up [3];
  logic signed [31:0] e3 [3];
  logic signed [63:0] prod;
  logic signed [AW-1:0] acc;

  function automatic logic signed [31:0] rnd_sat(input logic signed [AW-1:0] v,
                                                 input logic flip);
    logic [AW-1:0] m;
    logic signed [AW-1:0] s;
    m = v[AW-1] ? (~v + 1'b1) : v;
    m = (m + (AW'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
    s = (v[AW-1] ^ flip) ? -$signed(m) : $signed(m);
    if (s[AW-1:31] == '0 || s[AW-1:31] == '1) begin
      return s[31:0];
    end else if (s[AW-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  // current vector: forward difference or (-dz, 0, dx)
  logic signed [DIFF_W-1:0] vc [3];
  always_comb begin
    if (!vsel) begin
      vc[0] = job.dif_x;
      vc[1] = job.dif_y;
      vc[2] = job.dif_z;
    end else begin
      vc[0] = -job.dif_z;
      vc[1] = '0;
      vc[2] = job.dif_x;
    end
  end

  logic [32:0] mmax;
  always_comb begin
    mmax = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > mmax) begin
      mmax = mag[2];
    end
  end

  logic [32:0] mag_cur;
  logic        neg_cur;
  always_comb begin
    case (idx)
      2'd0:    begin mag_cur = mag[0]; neg_cur = neg[0]; end
      2'd1:    begin mag_cur = mag[1]; neg_cur = neg[1]; end
      default: begin mag_cur = mag[2]; neg_cur = neg[2]; end
    endcase
  end

  // root step
  logic [63:0] trial;
  logic        take;
  assign trial = root + rbit;
  assign take  = (sum >= trial);

  // divide step
  logic [NW-1:0] num;
  logic [32:0]   dt;
  logic          ge;
  logic [QW-1:0] qfin;
  logic signed [31:0] unit;
  assign num  = (NW'(mag_cur[29:0]) << FRAC_BITS) + NW'(len >> 1);
  assign dt   = {rem, lo[QW-1]};
  assign ge   = (dt >= {1'b0, len});
  assign qfin = {quo[QW-2:0], ge};
  assign unit = neg_cur ? -$signed(32'(qfin)) : $signed(32'(qfin));

  // multiply-accumulate schedule
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic               pneg;
  logic               pend;
  always_comb begin
    opa  = '0;
    opb  = '0;
    pneg = 1'b0;
    pend = 1'b0;
    case (step)
      4'd0:  begin opa = r[2];  opb = f[1];      pneg = 1'b1; pend = 1'b1; end
      4'd1:  begin opa = r[2];  opb = f[0];                               end
      4'd2:  begin opa = r[0];  opb = f[2];      pneg = 1'b1; pend = 1'b1; end
      4'd3:  begin opa = r[0];  opb = f[1];                   pend = 1'b1; end
      4'd4:  begin opa = r[0];  opb = job.eye_x;                          end
      4'd5:  begin opa = r[1];  opb = job.eye_y;                          end
      4'd6:  begin opa = r[2];  opb = job.eye_z;              pend = 1'b1; end
      4'd7:  begin opa = up[0]; opb = job.eye_x;                          end
      4'd8:  begin opa = up[1]; opb = job.eye_y;                          end
      4'd9:  begin opa = up[2]; opb = job.eye_z;              pend = 1'b1; end
      4'd10: begin opa = f[0];  opb = job.eye_x;                          end
      4'd11: begin opa = f[1];  opb = job.eye_y;                          end
      4'd12: begin opa = f[2];  opb = job.eye_z;              pend = 1'b1; end
      default: begin end
    endcase
  end

  logic signed [AW-1:0] total;
  assign total = acc + (pneg ? -AW'(prod) : AW'(prod));

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign pop      = (state == S_IDLE) && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (!vsel ? job.fwd_zero : job.rgt_zero) begin
            state <= S_MUL;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (mmax < 33'(1 << 30) && mmax >= 33'(1 << 29)) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (idx == 2'd2) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (rbit == 64'd1) begin
            state <= S_DLOAD;
          end
        end
        S_DLOAD: state <= S_DSTEP;
        S_DSTEP: begin
          if (dcnt == DW'(QW-1)) begin
            if (idx != 2'd2) begin
              state <= S_DLOAD;
            end else if (!vsel) begin
              state <= S_PREP;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          state <= (step == 4'd12) ? S_EMIT : S_MUL;
        end
        S_EMIT: begin
          if (out_free) begin
            if (row == 2'd3) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        job   <= head_data;
        vsel  <= 1'b0;
        degen <= 1'b0;
        acc   <= '0;
        step  <= '0;
        row   <= '0;
        for (int i = 0; i < 3; i++) begin
          f[i] <= '0;
          r[i] <= '0;
        end
      end
      S_PREP: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= vc[i][DIFF_W-1];
          mag[i] <= vc[i][DIFF_W-1] ? 33'(-vc[i]) : 33'(vc[i]);
        end
        if (!vsel ? job.fwd_zero : job.rgt_zero) begin
          degen <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            f[i] <= '0;
          end
        end
        idx <= '0;
        sum <= '0;
      end
      S_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (mmax >= 33'(1 << 30)) begin
            mag[i] <= mag[i] >> 1;
          end else if (mmax < 33'(1 << 29)) begin
            mag[i] <= mag[i] << 1;
          end
        end
      end
      S_SQ: begin
        sum  <= sum + 64'(mag_cur[29:0]) * 64'(mag_cur[29:0]);
        idx  <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        root <= '0;
        rbit <= 64'd1 << 62;
      end
      S_ROOT: begin
        if (take) begin
          sum  <= sum - trial;
          root <= (root >> 1) + rbit;
        end else begin
          root <= root >> 1;
        end
        rbit <= rbit >> 2;
        len  <= take ? 32'((root >> 1) + rbit) : 32'(root >> 1);
      end
      S_DLOAD: begin
        rem  <= 32'(num >> QW);
        lo   <= num[QW-1:0];
        quo  <= '0;
        dcnt <= '0;
      end
      S_DSTEP: begin
        rem  <= ge ? 32'(dt - {1'b0, len}) : dt[31:0];
        lo   <= lo << 1;
        quo  <= qfin;
        dcnt <= dcnt + 1'b1;
        if (dcnt == DW'(QW-1)) begin
          for (int i = 0; i < 3; i++) begin
            if (idx == 2'(i)) begin
              if (!vsel) begin
                f[i] <= unit;
              end else begin
                r[i] <= unit;
              end
            end
          end
          if (idx == 2'd2) begin
            idx  <= '0;
            vsel <= 1'b1;
          end else begin
            idx <= idx + 2'd1;
          end
        end
      end
      S_MUL: begin
        prod <= opa * opb;
      end
      S_ACC: begin
        step <= step + 4'd1;
        if (pend) begin
          acc <= '0;
          case (step)
            4'd0:  up[0] <= rnd_sat(total, 1'b0);
            4'd2:  up[1] <= rnd_sat(total, 1'b0);
            4'd3:  up[2] <= rnd_sat(total, 1'b0);
            4'd6:  e3[0] <= rnd_sat(total, 1'b1);
            4'd9:  e3[1] <= rnd_sat(total, 1'b1);
            default: e3[2] <= rnd_sat(total, 1'b0);
          endcase
        end else begin
          acc <= total;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          row <= row + 2'd1;
          out_data.row_index  <= row;
          out_data.last_row   <= (row == 2'd3);
          out_data.degenerate <= degen;
          case (row)
            2'd0: begin
              out_data.entry_0 <= r[0];
              out_data.entry_1 <= up[0];
              out_data.entry_2 <= -f[0];
              out_data.entry_3 <= '0;
            end
            2'd1: begin
              out_data.entry_0 <= r[1];
              out_data.entry_1 <= up[1];
              out_data.entry_2 <= -f[1];
              out_data.entry_3 <= '0;
            end
            2'd2: begin
              out_data.entry_0 <= r[2];
              out_data.entry_1 <= up[2];
              out_data.entry_2 <= -f[2];
              out_data.entry_3 <= '0;
            end
            default: begin
              out_data.entry_0 <= e3[0];
              out_data.entry_1 <= e3[1];
              out_data.entry_2 <= e3[2];
              out_data.entry_3 <= 32'sd1 <<< FRAC_BITS;
            end
          endcase
        end
      end
      default: begin end
    endcase
  end

endmodule

// ----- rtl/core/look_at_view_matrix.sv -----
// top level of the look-at view matrix generator
// Each request carries a camera eye point and a target point (signed fixed point,
// FRAC_BITS fraction bits) and produces the 4x4 view matrix as four row results,
// rows 0 to 3 in order, last_row set on row 3. Rows 0-2 hold the right, up and
// negated forward components, row 3 the eye translation terms and one. Entries
// saturate to 32 bits; when eye equals target or the view is straight up or down,
// degenerate is set on all four rows and the rotation part is zero. A front end
// forms the view direction and classifies the request, then parks it in a
// two-entry queue, so up to two further requests are taken while one is being
// worked on. The back end does everything on one shared set of units: a
// normalizing shift of one bit per cycle, squaring of the three components, an
// integer square root, and three restoring divisions, all twice (forward, then
// right), followed by 13 products on one 32x32 multiplier and the four row
// outputs. The format is Q16.16 with the default FRAC_BITS; a request whose eye
// equals target skips the normalizing, square-root and divide steps. Rows leave
// through an output register; the back end holds each row in its emit state
// until the register is free, and it can start the next request while the last
// row waits to be taken.
module look_at_view_matrix #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lavm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lavm_pkg::out_t out_data
);
  import lavm_pkg::*;

  // front to queue
  logic push;
  logic q_full;
  job_t job;

  // queue to back
  logic head_valid;
  job_t head_data;
  logic pop;

  lavm_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .job      (job)
  );

  lavm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  lavm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
